/* rtl/dvtc_pkg.sv */
// Package for the debounced volume and tempo control block.
// Holds register reset values, register indexes, stream field positions and the
// sequencer state type. Used by the top level and its checker.
package dvtc_pkg;

	// Default parameter values.
	localparam int TIMER_BITS_DEF  = 11;
	localparam int VOLUME_BITS_DEF = 7;

	// Fixed field widths.
	localparam int TIME_W   = 10;
	localparam int VOL_W    = 7;
	localparam int LEVEL_W  = 4;
	localparam int TEMPO_W  = 10;
	localparam int DELTA_W  = 10;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 40;

	// Reset values of the configuration registers and of the volume.
	localparam logic [TIME_W-1:0]  DEBOUNCE_RESET    = 10'd110;
	localparam logic [TIME_W-1:0]  REPEAT_RESET      = 10'd80;
	localparam logic [VOL_W-1:0]   VOL_LIMIT_RESET   = 7'd120;
	localparam logic [VOL_W-1:0]   STEP_RESET        = 7'd10;
	localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 4'd11;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX_RESET   = 10'd599;
	localparam logic [TEMPO_W-1:0] TEMPO_FLOOR_RESET = 10'd60;
	localparam int                 VOLUME_RESET      = 90;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
	localparam logic [2:0] REG_REPEAT      = 3'd1;
	localparam logic [2:0] REG_VOL_LIMIT   = 3'd2;
	localparam logic [2:0] REG_VOLUME_STEP = 3'd3;
	localparam logic [2:0] REG_LEVEL_COUNT = 3'd4;
	localparam logic [2:0] REG_TEMPO_MAX   = 3'd5;
	localparam logic [2:0] REG_TEMPO_FLOOR = 3'd6;

	// Input item kind carried on s_axis_tuser.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KNOB = 1'b1;

	// Result field positions in m_axis_tdata.
	localparam int O_VOLUME_LSB  = 0;
	localparam int O_VSET        = 7;
	localparam int O_LEVEL_LSB   = 8;
	localparam int O_TEMPO_LSB   = 12;
	localparam int O_TSET        = 22;
	localparam int O_PASSED      = 23;
	localparam int O_DISP_LSB    = 24;
	localparam int O_DUPD        = 34;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} seq_state_t;

endpackage

/* rtl/debounced_volume_and_tempo_control.sv */
// An item is accepted in the idle state, then passes the divide state (VOLUME_BITS steps of
// the restoring level divider, one quotient bit a cycle) and the done state, which loads the
// output register once it is empty or read; m_axis_tvalid rises with that load. The next
// item is then taken while the result waits in the output register. Reset (arst_n low) is
// asynchronous: it loads the register defaults, volume 90, tempo 0, a saturated repeat timer
// and an empty output. Top level of the volume and tempo control; depends on dvtc_pkg.
module debounced_volume_and_tempo_control #(
	parameter int TIMER_BITS  = dvtc_pkg::TIMER_BITS_DEF,
	parameter int VOLUME_BITS = dvtc_pkg::VOLUME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream.
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [0] up_pressed, [1] down_pressed, [11:2] knob_delta, [15:12] zero
	input  logic [dvtc_pkg::IN_W-1:0]   s_axis_tdata,
	// [0] command: 0 = tick, 1 = knob turn
	input  logic                        s_axis_tuser,
	// Result stream.
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [6:0] volume, [7] volume_set, [11:8] volume_level, [21:12] tempo, [22] tempo_set,
	// [23] knob_passed, [33:24] display_value, [34] display_update, [39:35] zero
	output logic [dvtc_pkg::OUT_W-1:0]  m_axis_tdata,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dvtc_pkg::ADDR_W-1:0] paddr,
	input  logic [dvtc_pkg::DATA_W-1:0] pwdata,
	output logic [dvtc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import dvtc_pkg::*;

	// Common compare width for timers against the 10-bit registers.
	localparam int TW = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;
	// Width that holds a volume plus one step without overflow.
	localparam int CW = ((VOLUME_BITS > VOL_W) ? VOLUME_BITS : VOL_W) + 1;
	localparam int VMAX_INT = (1 << VOLUME_BITS) - 1;
	localparam int VOL_RST = (VOLUME_RESET < VMAX_INT) ? VOLUME_RESET : VMAX_INT;
	localparam int CNT_W = $clog2(VOLUME_BITS);

	localparam logic [TIMER_BITS-1:0]  TMAX = '1;
	localparam logic [VOLUME_BITS-1:0] VMAX = '1;

	// Configuration registers.
	logic [TIME_W-1:0]  debounce_ms_q;
	logic [TIME_W-1:0]  repeat_ms_q;
	logic [VOL_W-1:0]   vol_limit_q;
	logic [VOL_W-1:0]   volume_step_q;
	logic [LEVEL_W-1:0] level_count_q;
	logic [TEMPO_W-1:0] tempo_max_q;
	logic [TEMPO_W-1:0] tempo_floor_q;

	// Control state of the button and knob logic.
	logic                   prev_up_q, prev_down_q, knob_turning_q;
	logic [TIMER_BITS-1:0]  stable_ticks_q, repeat_ticks_q;
	logic [TEMPO_W-1:0]     tempo_q;
	logic [VOLUME_BITS-1:0] volume_q;

	// Sequencer, divider and per-item flags.
	seq_state_t             state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [VOL_W-1:0]       rem_q;
	logic [VOLUME_BITS-1:0] quo_q;
	logic                   vset_q, tset_q, passed_q;

	// Output register.
	logic                   m_valid_q;
	logic [OUT_W-1:0]       m_data_q;

	logic                   in_xfer, cfg_wr, out_load, div_step;
	logic [2:0]             reg_idx;

	// Input field views.
	logic                   up_in, dn_in;
	logic signed [DELTA_W-1:0] knob_delta;

	// Next values computed for an accepted item.
	logic                   changed, step_ok, is_tick, tempo_hit;
	logic [TIMER_BITS-1:0]  stable_n, repeat_n, repeat_inc;
	logic                   knob_turning_n;
	logic [CW-1:0]          cap, vol_ext, step_ext, vol_raw, vol_clamped;
	logic [VOLUME_BITS-1:0] volume_n;
	logic signed [TEMPO_W+1:0] tsum, tclamp;
	logic [TEMPO_W-1:0]     tempo_n;

	// Divider step, level and the assembled result word.
	logic [VOL_W:0]         rem_sh;
	logic                   qbit;
	logic [LEVEL_W-1:0]     level;
	logic [TEMPO_W-1:0]     disp;
	logic [OUT_W-1:0]       out_word;

	assign up_in      = s_axis_tdata[0];
	assign dn_in      = s_axis_tdata[1];
	assign knob_delta = s_axis_tdata[DELTA_W+1:2];

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign reg_idx  = paddr[4:2];
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// Configuration write and read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= DEBOUNCE_RESET;
			repeat_ms_q   <= REPEAT_RESET;
			vol_limit_q   <= VOL_LIMIT_RESET;
			volume_step_q <= STEP_RESET;
			level_count_q <= LEVEL_COUNT_RESET;
			tempo_max_q   <= TEMPO_MAX_RESET;
			tempo_floor_q <= TEMPO_FLOOR_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DEBOUNCE:    debounce_ms_q <= pwdata[TIME_W-1:0];
				REG_REPEAT:      repeat_ms_q   <= pwdata[TIME_W-1:0];
				REG_VOL_LIMIT:   vol_limit_q   <= pwdata[VOL_W-1:0];
				REG_VOLUME_STEP: volume_step_q <= pwdata[VOL_W-1:0];
				REG_LEVEL_COUNT: level_count_q <= pwdata[LEVEL_W-1:0];
				REG_TEMPO_MAX:   tempo_max_q   <= pwdata[TEMPO_W-1:0];
				REG_TEMPO_FLOOR: tempo_floor_q <= pwdata[TEMPO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE:    prdata = DATA_W'(debounce_ms_q);
			REG_REPEAT:      prdata = DATA_W'(repeat_ms_q);
			REG_VOL_LIMIT:   prdata = DATA_W'(vol_limit_q);
			REG_VOLUME_STEP: prdata = DATA_W'(volume_step_q);
			REG_LEVEL_COUNT: prdata = DATA_W'(level_count_q);
			REG_TEMPO_MAX:   prdata = DATA_W'(tempo_max_q);
			REG_TEMPO_FLOOR: prdata = DATA_W'(tempo_floor_q);
			default:         prdata = '0;
		endcase
	end

	// Item logic. A tick advances both timers, restarts the debounce count on any
	// change of the button levels, and may step the volume. A knob turn while up is
	// held sets the tempo; any other knob turn is handed on.
	always_comb begin
		is_tick    = (s_axis_tuser == CMD_TICK);
		repeat_inc = (repeat_ticks_q < TMAX) ? repeat_ticks_q + 1'b1 : repeat_ticks_q;
		changed    = (up_in != prev_up_q) || (dn_in != prev_down_q);
		if (changed) begin
			stable_n       = '0;
			knob_turning_n = 1'b0;
		end else begin
			stable_n       = (stable_ticks_q < TMAX) ? stable_ticks_q + 1'b1 : stable_ticks_q;
			knob_turning_n = knob_turning_q;
		end
		step_ok = (TW'(stable_n) > TW'(debounce_ms_q)) && !knob_turning_n &&
			(up_in || dn_in) && (TW'(repeat_inc) >= TW'(repeat_ms_q));
		repeat_n = step_ok ? '0 : repeat_inc;

		// Volume step with clamping to the smaller of the volume limit and the storage range.
		cap      = (CW'(vol_limit_q) < CW'(VMAX)) ? CW'(vol_limit_q) : CW'(VMAX);
		vol_ext  = CW'(volume_q);
		step_ext = CW'(volume_step_q);
		if (dn_in)
			vol_raw = (vol_ext < step_ext) ? '0 : vol_ext - step_ext;
		else
			vol_raw = vol_ext + step_ext;
		vol_clamped = (vol_raw > cap) ? cap : vol_raw;
		volume_n    = (is_tick && step_ok) ? VOLUME_BITS'(vol_clamped) : volume_q;

		// Tempo update: clamp to 0 and tempo_max, then snap values under the floor.
		tempo_hit = !is_tick && prev_up_q;
		tsum = $signed({2'b00, tempo_q}) + (TEMPO_W+2)'(knob_delta);
		tclamp = tsum;
		if (tclamp < 0)
			tclamp = '0;
		if (tclamp > $signed({2'b00, tempo_max_q}))
			tclamp = $signed({2'b00, tempo_max_q});
		if (tclamp < $signed({2'b00, tempo_floor_q}))
			tclamp = (knob_delta > 0) ? $signed({2'b00, tempo_floor_q}) : '0;
		tempo_n = tclamp[TEMPO_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_up_q      <= 1'b0;
			prev_down_q    <= 1'b0;
			stable_ticks_q <= '0;
			repeat_ticks_q <= TMAX;
			knob_turning_q <= 1'b0;
			tempo_q        <= '0;
			volume_q       <= VOLUME_BITS'(VOL_RST);
		end else if (in_xfer) begin
			if (is_tick) begin
				prev_up_q      <= up_in;
				prev_down_q    <= dn_in;
				stable_ticks_q <= stable_n;
				repeat_ticks_q <= repeat_n;
				knob_turning_q <= knob_turning_n;
				volume_q       <= volume_n;
			end else if (tempo_hit) begin
				tempo_q        <= tempo_n;
				knob_turning_q <= 1'b1;
			end
		end
	end

	// Sequencer: accept, divide for the level, then hand the result to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		div_step = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				div_step = 1'b1;
				if (cnt_q == '0)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Restoring divider: one quotient bit of volume / volume_step per cycle.
	assign rem_sh = {rem_q, quo_q[VOLUME_BITS-1]};
	assign qbit   = (rem_sh >= (VOL_W+1)'(volume_step_q));

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			quo_q    <= volume_n;
			rem_q    <= '0;
			cnt_q    <= CNT_W'(VOLUME_BITS - 1);
			vset_q   <= is_tick && step_ok;
			tset_q   <= tempo_hit;
			passed_q <= !is_tick && !prev_up_q;
		end else if (div_step) begin
			rem_q <= qbit ? VOL_W'(rem_sh - (VOL_W+1)'(volume_step_q)) : rem_sh[VOL_W-1:0];
			quo_q <= {quo_q[VOLUME_BITS-2:0], qbit};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// A zero step shows the full level count; otherwise the quotient, capped.
	always_comb begin
		if (volume_step_q == '0 || quo_q >= VOLUME_BITS'(level_count_q))
			level = level_count_q;
		else
			level = quo_q[LEVEL_W-1:0];
		if (vset_q)
			disp = TEMPO_W'(level);
		else if (tset_q)
			disp = tempo_q;
		else
			disp = '0;

		out_word                         = '0;
		out_word[O_VOLUME_LSB +: VOL_W]  = VOL_W'(volume_q);
		out_word[O_VSET]                 = vset_q;
		out_word[O_LEVEL_LSB +: LEVEL_W] = level;
		out_word[O_TEMPO_LSB +: TEMPO_W] = tempo_q;
		out_word[O_TSET]                 = tset_q;
		out_word[O_PASSED]               = passed_q;
		out_word[O_DISP_LSB +: TEMPO_W]  = disp;
		out_word[O_DUPD]                 = vset_q || tset_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_data_q <= out_word;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

/* rtl/dvtc_checker.sv */
// Port-level checker for the debounced volume and tempo control, bound to the top level.
// Depends on dvtc_pkg for the result field positions.
module dvtc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [dvtc_pkg::OUT_W-1:0]  m_axis_tdata
);
	import dvtc_pkg::*;

	// A stalled result must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// An item passes through the level divider before the next is taken, so no transfer follows directly.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while busy");

	// The display is updated exactly when volume or tempo was set.
	a_disp_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[O_DUPD] == (m_axis_tdata[O_VSET] || m_axis_tdata[O_TSET]))
		else $error("display_update does not match the set flags");

	// At most one of volume set, tempo set and knob passed per result.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0({m_axis_tdata[O_VSET], m_axis_tdata[O_TSET],
			m_axis_tdata[O_PASSED]}))
		else $error("more than one action flagged");

endmodule

bind debounced_volume_and_tempo_control dvtc_checker u_dvtc_checker (.*);
